// ===== design/rnta_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix number to ASCII package
// Shared constants, command and status types, and the digit character map.
// ----------------------------------------------------------------------------
package rnta_pkg;

   localparam int VALUE_BITS_DEFAULT = 64;

   // Quotient bits resolved per divide cycle.
   localparam int DIV_STEP_BITS = 8;

   localparam logic [4:0] RADIX_MIN  = 5'd8;
   localparam logic [4:0] RADIX_MAX  = 5'd16;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;

   typedef struct packed {
      logic load;
      logic sign_load;
      logic div_first;
      logic div_step;
      logic push;
      logic pop;
   } cmd_type;

   typedef struct packed {
      logic req_negative;
      logic quot_zero;
      logic count_one;
   } status_type;

   // Maps a digit value onto the lowercase alphabet 0123456789abcdef.
   function automatic logic [7:0] digit_char(input logic [3:0] digit);
      logic [7:0] result;
      if (digit < 4'd10) begin
         result = CHAR_ZERO + {4'b0000, digit};
      end else begin
         result = CHAR_LOWER_A + {4'b0000, digit} - 8'd10;
      end
      return result;
   endfunction

endpackage

// ===== design/rnta_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Carries one number, its radix and its signed flag per transfer.
// ----------------------------------------------------------------------------
interface rnta_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] value;
   logic [4:0]  radix;
   logic        is_signed;

   modport source (output valid, output value, output radix, output is_signed, input ready);
   modport sink   (input valid, input value, input radix, input is_signed, output ready);
endinterface

// ===== design/rnta_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Carries one ASCII character and an end-of-number flag per transfer.
// ----------------------------------------------------------------------------
interface rnta_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== design/rnta_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix conversion datapath
// Holds the working dividend, runs the chunked restoring division by the
// radix, stacks the remainders and registers the outgoing character.
// ----------------------------------------------------------------------------
module rnta_dpath #(
   parameter int VALUE_BITS = rnta_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [63:0]         req_value,
   input  logic [4:0]          req_radix,
   input  logic                req_is_signed,
   input  rnta_pkg::cmd_type   cmd,
   output rnta_pkg::status_type status,
   output logic [7:0]          rsp_character
);

   localparam int STEP       = rnta_pkg::DIV_STEP_BITS;
   localparam int PAD_BITS   = ((VALUE_BITS + STEP - 1) / STEP) * STEP;
   // Octal is the smallest radix and needs the most digits.
   localparam int MAX_DIGITS = (VALUE_BITS + 2) / 3;
   localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W      = $clog2(MAX_DIGITS);

   logic [PAD_BITS-1:0]   work_ff;
   logic [PAD_BITS-1:0]   work_in;
   logic [4:0]            radix_ff;
   logic [4:0]            radix_sat;
   logic [3:0]            rem_ff;
   logic [3:0]            rem_in;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic [CNT_W-1:0]      count_dec;
   logic [IDX_W-1:0]      top_idx;
   logic [3:0]            digits_ff [MAX_DIGITS];
   logic [7:0]            char_ff;
   logic [VALUE_BITS-1:0] value_bits;
   logic [VALUE_BITS-1:0] magnitude;
   logic                  negative;
   logic [STEP-1:0]       chunk;
   logic [STEP-1:0]       qbits;
   logic [4:0]            partial;

   assign value_bits = req_value[VALUE_BITS-1:0];
   assign negative   = req_is_signed & value_bits[VALUE_BITS-1];
   assign magnitude  = negative ? (VALUE_BITS'(0) - value_bits) : value_bits;

   always_comb begin
      if (req_radix < rnta_pkg::RADIX_MIN) begin
         radix_sat = rnta_pkg::RADIX_MIN;
      end else if (req_radix > rnta_pkg::RADIX_MAX) begin
         radix_sat = rnta_pkg::RADIX_MAX;
      end else begin
         radix_sat = req_radix;
      end
   end

   // One restoring step per quotient bit. The remainder stays below the
   // radix, so the shifted partial value always fits in five bits.
   assign chunk = work_ff[PAD_BITS-1 -: STEP];

   always_comb begin
      rem_in  = cmd.div_first ? 4'd0 : rem_ff;
      qbits   = '0;
      partial = '0;
      for (int i = STEP - 1; i >= 0; i--) begin
         partial = {rem_in, chunk[i]};
         if (partial >= radix_ff) begin
            rem_in   = 4'(partial - radix_ff);
            qbits[i] = 1'b1;
         end else begin
            rem_in = partial[3:0];
         end
      end
   end

   assign work_in   = (work_ff << STEP) | PAD_BITS'(qbits);
   assign count_dec = count_ff - CNT_W'(1);
   assign top_idx   = count_dec[IDX_W-1:0];

   always_comb begin
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         count_in = count_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         work_ff  <= PAD_BITS'(magnitude);
         radix_ff <= radix_sat;
      end else if (cmd.div_step) begin
         work_ff <= work_in;
         rem_ff  <= rem_in;
      end
      if (cmd.push) begin
         digits_ff[count_ff[IDX_W-1:0]] <= rem_ff;
      end
      if (cmd.sign_load) begin
         char_ff <= rnta_pkg::CHAR_MINUS;
      end else if (cmd.pop) begin
         char_ff <= rnta_pkg::digit_char(digits_ff[top_idx]);
      end
   end

   assign status.req_negative = negative;
   assign status.quot_zero    = (work_ff == '0);
   assign status.count_one    = (count_ff == CNT_W'(1));
   assign rsp_character       = char_ff;

endmodule

// ===== design/rnta_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix conversion controller
// Sequences sign output, digit divisions and most-significant-first output.
// ----------------------------------------------------------------------------
module rnta_ctrl #(
   parameter int VALUE_BITS = rnta_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_last,
   output rnta_pkg::cmd_type    cmd,
   input  rnta_pkg::status_type status
);

   localparam int STEP     = rnta_pkg::DIV_STEP_BITS;
   localparam int PAD_BITS = ((VALUE_BITS + STEP - 1) / STEP) * STEP;
   localparam int CHUNKS   = PAD_BITS / STEP;
   localparam int STEP_W   = $clog2(CHUNKS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SIGN,
      ST_DIVIDE,
      ST_STORE,
      ST_EMIT
   } state_type;

   state_type         state_ff;
   state_type         state_in;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              rsp_last_ff;
   logic              rsp_last_in;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = STEP_W'(CHUNKS);
               if (status.req_negative) begin
                  cmd.sign_load = 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_last_in   = 1'b0;
                  state_in      = ST_SIGN;
               end else begin
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_SIGN: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step  = 1'b1;
            cmd.div_first = (step_ff == STEP_W'(CHUNKS));
            step_in       = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.push = 1'b1;
            step_in  = STEP_W'(CHUNKS);
            state_in = status.quot_zero ? ST_EMIT : ST_DIVIDE;
         end
         ST_EMIT: begin
            // Refill the output register when empty or just drained; after the last, go idle.
            if (!rsp_valid_ff || rsp_ready) begin
               if (rsp_valid_ff && rsp_last_ff) begin
                  rsp_valid_in = 1'b0;
                  rsp_last_in  = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  cmd.pop      = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = status.count_one;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

// ===== design/radix_number_to_ascii_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix number to ASCII unit
// Converts one number per request into its ASCII digits in radix 8 to 16.
//
//   Channel  Dir  Transfer carries
//   req_bus  in   value[63:0], radix[4:0], is_signed
//   rsp_bus  out  character[7:0], last
//
// One number is handled at a time; the request side is ready only when idle.
// Each digit passes through the shared divider, which resolves eight quotient
// bits per cycle over the padded value, and then through a store step that
// pushes the remainder; a 64-bit number gives up to 22 octal digits.
// Digit characters leave back to back from an output register; a stalled response
// side simply holds the current character. Reset is synchronous and leaves
// the unit idle with no clearing pass.
// ----------------------------------------------------------------------------
module radix_number_to_ascii_unit #(
   parameter int VALUE_BITS = rnta_pkg::VALUE_BITS_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   rnta_req_if.sink     req_bus,
   rnta_rsp_if.source   rsp_bus
);

   rnta_pkg::cmd_type    cmd;
   rnta_pkg::status_type status;

   rnta_ctrl #(
      .VALUE_BITS (VALUE_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_last  (rsp_bus.last),
      .cmd       (cmd),
      .status    (status)
   );

   rnta_dpath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_bus.value),
      .req_radix     (req_bus.radix),
      .req_is_signed (req_bus.is_signed),
      .cmd           (cmd),
      .status        (status),
      .rsp_character (rsp_bus.character)
   );

endmodule

// ===== design/rnta_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix number to ASCII port checker
// Watches the unit's channels for ordering and framing of character runs.
// ----------------------------------------------------------------------------
module rnta_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_character,
   input logic       rsp_last
);

   logic busy_ff;
   logic busy_in;

   // A number is in flight from its request transfer until its last character.
   always_comb begin
      busy_in = busy_ff;
      if (req_valid && req_ready) begin
         busy_in = 1'b1;
      end else if (rsp_valid && rsp_ready && rsp_last) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !busy_ff)
      else $error("request taken while a number is still being output");

   a_rsp_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy_ff)
      else $error("character presented with no number in flight");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_character == rnta_pkg::CHAR_MINUS) |-> !rsp_last)
      else $error("minus sign ended a number");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_character)
                                     && $stable(rsp_last)))
      else $error("stalled character changed or dropped");

endmodule

bind radix_number_to_ascii_unit rnta_checker u_rnta_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_character (rsp_bus.character),
   .rsp_last      (rsp_bus.last)
);
